// ----- hdl/hich_pkg.sv -----
package hich_pkg;

    localparam int IO_W         = 16;
    localparam int ANG_FRAC     = 16;
    localparam int ANG_W        = 26;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_SAMPLE  = 2'd1,
        CMD_FINISH  = 2'd2,
        CMD_MEASURE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CORDIC,
        ST_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_WRAP,
        CS_ROUND
    } cordic_state_t;

    typedef struct packed {
        logic            done;
        logic [IO_W-1:0] heading;
    } heading_res_t;

    // atan(2^-i) in degrees, Q16
    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    localparam logic signed [ANG_W-1:0] ANG_HALF = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_FULL = 26'sd23592960;

endpackage

// ----- hdl/hich_axis_lane.sv -----
module hich_axis_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  hich_pkg::cmd_t                cmd,
    input  logic signed [SAMPLE_BITS-1:0] raw,
    output logic signed [SAMPLE_BITS-1:0] res
);
    import hich_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] S_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] off_reg, off_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic signed [SAMPLE_BITS:0]   sum;
    logic signed [SAMPLE_BITS:0]   sum_adj;
    logic signed [SAMPLE_BITS-1:0] half;
    logic signed [SAMPLE_BITS-1:0] diff;

    // midpoint, truncated toward zero
    assign sum     = {min_reg[SAMPLE_BITS-1], min_reg} + {max_reg[SAMPLE_BITS-1], max_reg};
    assign sum_adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]};
    assign half    = sum_adj[SAMPLE_BITS:1];
    assign diff    = raw - off_reg;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        off_next = off_reg;
        res_next = '0;
        if (load)
        begin
            case (cmd)
                CMD_START:
                begin
                    min_next = S_HI;
                    max_next = S_LO;
                end
                CMD_SAMPLE:
                begin
                    if (raw < min_reg)
                        min_next = raw;
                    if (raw > max_reg)
                        max_next = raw;
                end
                CMD_FINISH:
                begin
                    off_next = half;
                    res_next = half;
                end
                CMD_MEASURE:
                    res_next = diff;
                default:
                    res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= S_HI;
            max_reg <= S_LO;
            off_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            off_reg <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

    a_track_order: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cmd == CMD_SAMPLE) |=> (max_reg >= min_reg))
        else $error("tracker max below min after sample");

endmodule

// ----- hdl/hich_cordic.sv -----
module hich_cordic #(
    parameter int SAMPLE_BITS       = 16,
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] cx,
    input  logic signed [SAMPLE_BITS-1:0] cy,
    output hich_pkg::heading_res_t        res
);
    import hich_pkg::*;

    localparam int XW = SAMPLE_BITS + 11;
    localparam int SH = ANG_FRAC - HEADING_FRAC_BITS;
    localparam int HW = HEADING_FRAC_BITS + 10;
    localparam logic signed [ANG_W-1:0] RND = ANG_W'(1) <<< (SH - 1);
    localparam logic [HW-1:0] TOP = HW'(360) << HEADING_FRAC_BITS;

    cordic_state_t state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic zero_reg, zero_next;

    logic signed [XW-1:0] x_init, y_init;
    logic signed [XW-1:0] dx, dy;
    logic                 y_pos;
    logic [HW-1:0]        h_raw, h_wrap;

    assign x_init = XW'(cx) <<< 8;
    assign y_init = XW'(cy) <<< 8;
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign y_pos  = !y_reg[XW-1] && (|y_reg);
    assign h_raw  = HW'($unsigned(ang_reg) >> SH);
    assign h_wrap = (h_raw >= TOP) ? (h_raw - TOP) : h_raw;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
                if (start)
                    state_next = CS_RUN;
            CS_RUN:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = CS_WRAP;
            CS_WRAP:
                state_next = CS_ROUND;
            CS_ROUND:
                state_next = CS_IDLE;
            default:
                state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        zero_next = zero_reg;
        case (state_reg)
            CS_IDLE:
                if (start)
                begin
                    step_next = '0;
                    zero_next = (cx == '0) && (cy == '0);
                    if (cx[SAMPLE_BITS-1])
                    begin
                        x_next   = -x_init;
                        y_next   = -y_init;
                        ang_next = ANG_HALF;
                    end
                    else
                    begin
                        x_next   = x_init;
                        y_next   = y_init;
                        ang_next = '0;
                    end
                end
            CS_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (y_pos)
                begin
                    x_next   = x_reg + dx;
                    y_next   = y_reg - dy;
                    ang_next = ang_reg + ATAN_TAB[step_reg];
                end
                else
                begin
                    x_next   = x_reg - dx;
                    y_next   = y_reg + dy;
                    ang_next = ang_reg - ATAN_TAB[step_reg];
                end
            end
            CS_WRAP:
                ang_next = ang_reg + (ang_reg[ANG_W-1] ? ANG_FULL : '0) + RND;
            CS_ROUND:
                ang_next = ang_reg;
            default:
                ang_next = ang_reg;
        endcase
    end

    always_comb
    begin
        res.done    = (state_reg == CS_ROUND);
        res.heading = zero_reg ? '0 : IO_W'(h_wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        zero_reg <= zero_next;
    end

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_RUN && step_reg == STEP_W'(CORDIC_STEPS - 1)) |=>
        (state_reg == CS_WRAP))
        else $error("rotation did not end after last step");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_ROUND) |-> (h_wrap < TOP))
        else $error("heading outside one turn");

endmodule

// ----- hdl/hard_iron_calibrated_compass_heading.sv -----
// Flow: an accepted word is evaluated, measure words then run through the CORDIC unit,
// and the result is held until it moves to the output register. One word at a time:
// the next word is taken only after that move, which stalls while the output is full and not ready.
// Measure words pass through the 16-step CORDIC unit plus wrap and round.
// Reset: asynchronous, active low; clears trackers to full scale, offsets to
// zero and empties the output register.
module hard_iron_calibrated_compass_heading #(
    parameter int SAMPLE_BITS       = 16,
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic signed [hich_pkg::IO_W-1:0] x_raw,
    input  logic signed [hich_pkg::IO_W-1:0] y_raw,
    input  logic signed [hich_pkg::IO_W-1:0] z_raw,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [hich_pkg::IO_W-1:0] x_out,
    output logic signed [hich_pkg::IO_W-1:0] y_out,
    output logic signed [hich_pkg::IO_W-1:0] z_out,
    output logic [hich_pkg::IO_W-1:0]       heading_deg,
    output logic                            heading_valid
);
    import hich_pkg::*;

    top_state_t state_reg, state_next;
    cmd_t       cmd_reg;
    logic       accept;
    logic       cordic_start;
    logic       load_out;
    logic       out_valid_reg;
    logic [IO_W-1:0] heading_reg, heading_next;
    logic signed [IO_W-1:0] x_out_reg, y_out_reg, z_out_reg;
    logic [IO_W-1:0] hd_out_reg;
    logic            hv_out_reg;

    logic signed [SAMPLE_BITS-1:0] x_res, y_res, z_res;
    heading_res_t cres;

    assign accept = in_valid && in_ready;

    hich_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .cmd  (cmd_t'(cmd)),
        .raw  ($signed(x_raw[SAMPLE_BITS-1:0])),
        .res  (x_res)
    );

    hich_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .cmd  (cmd_t'(cmd)),
        .raw  ($signed(y_raw[SAMPLE_BITS-1:0])),
        .res  (y_res)
    );

    hich_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .cmd  (cmd_t'(cmd)),
        .raw  ($signed(z_raw[SAMPLE_BITS-1:0])),
        .res  (z_res)
    );

    hich_cordic #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .HEADING_FRAC_BITS(HEADING_FRAC_BITS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cordic_start),
        .cx   (x_res),
        .cy   (y_res),
        .res  (cres)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EVAL;
            ST_EVAL:
                state_next = (cmd_reg == CMD_MEASURE) ? ST_CORDIC : ST_HOLD;
            ST_CORDIC:
                if (cres.done)
                    state_next = ST_HOLD;
            ST_HOLD:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cordic_start = 1'b0;
        load_out     = 1'b0;
        heading_next = heading_reg;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_EVAL:
            begin
                cordic_start = (cmd_reg == CMD_MEASURE);
                heading_next = '0;
            end
            ST_CORDIC:
                if (cres.done)
                    heading_next = cres.heading;
            ST_HOLD:
                load_out = !out_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_t'(cmd);
        heading_reg <= heading_next;
        if (load_out)
        begin
            x_out_reg  <= IO_W'(x_res);
            y_out_reg  <= IO_W'(y_res);
            z_out_reg  <= IO_W'(z_res);
            hd_out_reg <= heading_reg;
            hv_out_reg <= (cmd_reg == CMD_MEASURE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign x_out         = x_out_reg;
    assign y_out         = y_out_reg;
    assign z_out         = z_out_reg;
    assign heading_deg   = hd_out_reg;
    assign heading_valid = hv_out_reg;

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted word did not reach evaluation");

    a_done_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        cres.done |-> (state_reg == ST_CORDIC))
        else $error("heading done outside measure");

    a_no_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !heading_valid) |-> (heading_deg == '0))
        else $error("heading set on non-measure word");

endmodule
